### hdl/dtpr_pkg.sv
// ----------------------------------------------------------------------------
// dtpr_pkg: shared types and constants of the text packet receiver
// Item codes, framing characters, phase encoding and the transfer structs.
// ----------------------------------------------------------------------------
package dtpr_pkg;

   // item kinds on the request channel
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_BYTE  = 2'd0;
   localparam kind_type KIND_CLEAR = 2'd1;
   localparam kind_type KIND_READ  = 2'd2;

   // framing characters
   localparam logic [7:0] CH_START = 8'h40;   // '@'
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TERM  = 8'h00;

   // reported phase codes
   typedef logic [1:0] phase_code_type;
   localparam phase_code_type PHASE_IDLE     = 2'd0;
   localparam phase_code_type PHASE_PAYLOAD  = 2'd1;
   localparam phase_code_type PHASE_AFTER_CR = 2'd2;

   // reported length saturates here
   localparam logic [6:0] LEN_MAX = 7'd127;

   // receiver phase machine
   typedef enum logic [2:0] {
      ST_IDLE     = 3'b001,
      ST_PAYLOAD  = 3'b010,
      ST_AFTER_CR = 3'b100
   } phase_type;

   // one accepted request
   typedef struct packed {
      kind_type   kind;
      logic [7:0] rx_byte;
      logic [6:0] read_index;
   } item_type;

   // status fields of one response
   typedef struct packed {
      logic           packet_ready;
      logic [6:0]     packet_length;
      logic           overflow;
      phase_code_type receiver_phase;
   } status_type;

   // store write request (address travels beside it)
   typedef struct packed {
      logic       en;
      logic [7:0] data;
   } store_wr_type;

endpackage

### hdl/dtpr_if.sv
// ----------------------------------------------------------------------------
// dtpr_if: request and response channels of the text packet receiver
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface dtpr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;
   logic [6:0] read_index;

   modport source (output valid, kind, rx_byte, read_index, input ready);
   modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface dtpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       packet_ready;
   logic [6:0] packet_length;
   logic       overflow;
   logic [1:0] receiver_phase;

   modport source (output valid, read_data, packet_ready, packet_length, overflow,
                   receiver_phase, input ready);
   modport sink   (input valid, read_data, packet_ready, packet_length, overflow,
                   receiver_phase, output ready);
endinterface

### hdl/dtpr_store.sv
// ----------------------------------------------------------------------------
// dtpr_store: packet byte store
// One write port from the framer, one read port with registered data.
// Reads past the store depth or from non-read items return zero.
// ----------------------------------------------------------------------------
module dtpr_store
   import dtpr_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128,
   parameter int ADDR_WIDTH   = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  store_wr_type          wr,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic                  rd_en,
   input  logic                  rd_sel,
   input  logic [6:0]            rd_index,
   output logic [7:0]            rd_data
);

   localparam int IW = ((ADDR_WIDTH > 7) ? ADDR_WIDTH : 7) + 1;

   logic [7:0]            mem [BUFFER_DEPTH];
   logic [7:0]            mem_q_ff;
   logic                  hit_ff;
   logic                  hit_in;
   logic [IW-1:0]         index_ext;
   logic [ADDR_WIDTH-1:0] rd_addr;

   // range check on the requested position
   assign index_ext = IW'(rd_index);
   assign rd_addr   = index_ext[ADDR_WIDTH-1:0];
   assign hit_in    = rd_sel && (index_ext < IW'(BUFFER_DEPTH));

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= hit_in;
      end
   end

   assign rd_data = hit_ff ? mem_q_ff : 8'h00;

endmodule

### hdl/dtpr_framer.sv
// ----------------------------------------------------------------------------
// dtpr_framer: packet framing state
// Phase machine, write position, ready/overflow flags and latched length.
// Gives the status after the current item and the store write for it.
// ----------------------------------------------------------------------------
module dtpr_framer
   import dtpr_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128,
   parameter int ADDR_WIDTH   = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  item_type              item,
   output status_type            status,
   output store_wr_type          wr,
   output logic [ADDR_WIDTH-1:0] wr_addr
);

   localparam logic [ADDR_WIDTH-1:0] POS_LIMIT = ADDR_WIDTH'(BUFFER_DEPTH - 1);
   localparam int LW = (ADDR_WIDTH > 7) ? ADDR_WIDTH : 7;

   phase_type             phase_ff, phase_in;
   logic [ADDR_WIDTH-1:0] wp_ff, wp_in;
   logic                  ready_ff, ready_in;
   logic                  ovf_ff, ovf_in;
   logic [6:0]            len_ff, len_in;
   logic [LW-1:0]         wp_ext;
   logic [6:0]            wp_sat;

   // saturated payload length
   assign wp_ext = LW'(wp_ff);
   assign wp_sat = (wp_ext > LW'(LEN_MAX)) ? LEN_MAX : wp_ext[6:0];

   // next state for the accepted item
   always_comb begin
      phase_in = phase_ff;
      wp_in    = wp_ff;
      ready_in = ready_ff;
      ovf_in   = ovf_ff;
      len_in   = len_ff;
      wr.en    = 1'b0;
      wr.data  = item.rx_byte;
      wr_addr  = wp_ff;
      if (accept) begin
         case (item.kind)
            KIND_BYTE: begin
               unique case (phase_ff)
                  ST_IDLE: begin
                     if (item.rx_byte == CH_START && !ready_ff) begin
                        phase_in = ST_PAYLOAD;
                        wp_in    = '0;
                        ovf_in   = 1'b0;
                     end
                  end
                  ST_PAYLOAD: begin
                     if (item.rx_byte == CH_CR) begin
                        phase_in = ST_AFTER_CR;
                     end else if (wp_ff < POS_LIMIT) begin
                        wr.en = 1'b1;
                        wp_in = wp_ff + ADDR_WIDTH'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ST_AFTER_CR: begin
                     if (item.rx_byte == CH_LF) begin
                        wr.en    = 1'b1;
                        wr.data  = CH_TERM;
                        len_in   = wp_sat;
                        ready_in = 1'b1;
                        phase_in = ST_IDLE;
                     end
                  end
                  default: begin
                     phase_in = ST_IDLE;
                  end
               endcase
            end
            KIND_CLEAR: begin
               ready_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_IDLE;
         wp_ff    <= '0;
         ready_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         wp_ff    <= wp_in;
         ready_ff <= ready_in;
         ovf_ff   <= ovf_in;
         len_ff   <= len_in;
      end
   end

   // status after the item
   always_comb begin
      status.packet_ready  = ready_in;
      status.packet_length = len_in;
      status.overflow      = ovf_in;
      unique case (phase_in)
         ST_IDLE:     status.receiver_phase = PHASE_IDLE;
         ST_PAYLOAD:  status.receiver_phase = PHASE_PAYLOAD;
         ST_AFTER_CR: status.receiver_phase = PHASE_AFTER_CR;
         default:     status.receiver_phase = PHASE_IDLE;
      endcase
   end

   // a pending packet blocks any new start, so the machine sits idle
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> phase_ff == ST_IDLE)
      else $error("packet pending outside idle phase");

   // write position never passes the terminator slot
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= POS_LIMIT)
      else $error("write position beyond store");

   // overflow only once the store is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> wp_ff == POS_LIMIT)
      else $error("overflow flagged with room left");

endmodule

### hdl/delimited_text_packet_receiver.sv
// ----------------------------------------------------------------------------
// delimited_text_packet_receiver: frames '@' payload CR LF text packets
// Top level: request register stage, framer, byte store and response register.
// ----------------------------------------------------------------------------
// Takes one item per cycle (received byte, clear-ready or store read) while
// the response side does not stall, and returns one response per item,
// carrying the store byte for reads and the status after the item. Each item
// passes the middle stage, where the store's registered read port holds its
// read data, then the response register. Stalls on the response side hold one
// item in the middle stage and one in the response register before the
// request channel drops ready. The store needs no clearing pass; entries not
// written since reset read back undefined.
module delimited_text_packet_receiver
   import dtpr_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   dtpr_req_if.sink    req,
   dtpr_rsp_if.source  rsp
);

   localparam int ADDR_WIDTH = $clog2(BUFFER_DEPTH);

   item_type              item;
   logic                  accept;
   logic                  advance;
   status_type            status;
   store_wr_type          wr;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic [7:0]            rd_data;

   logic                  s1_valid_ff, s1_valid_in;
   status_type            s1_status_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [7:0]            rsp_data_ff;

   // handshake
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   assign item.kind       = req.kind;
   assign item.rx_byte    = req.rx_byte;
   assign item.read_index = req.read_index;

   dtpr_framer #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (item),
      .status  (status),
      .wr      (wr),
      .wr_addr (wr_addr)
   );

   dtpr_store #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .rd_en    (accept),
      .rd_sel   (item.kind == KIND_READ),
      .rd_index (item.read_index),
      .rd_data  (rd_data)
   );

   // valid flags of the two stages
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the middle stage and response register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
      end
      if (advance && s1_valid_ff) begin
         rsp_status_ff <= s1_status_ff;
         rsp_data_ff   <= rd_data;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.read_data      = rsp_data_ff;
   assign rsp.packet_ready   = rsp_status_ff.packet_ready;
   assign rsp.packet_length  = rsp_status_ff.packet_length;
   assign rsp.overflow       = rsp_status_ff.overflow;
   assign rsp.receiver_phase = rsp_status_ff.receiver_phase;

endmodule

### bench/delimited_text_packet_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_text_packet_receiver_tb: self-checking bench of the packet receiver
// Drives byte, clear and read items over the request channel and checks every
// response, field by field, against a cycle-free model of the framer and store.
// Directed framing cases come first, then an overlong packet, a long response
// stall and random traffic.
// ----------------------------------------------------------------------------
module delimited_text_packet_receiver_tb
   import dtpr_pkg::*;
();

   localparam int DEPTH        = 128;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 1200;
   localparam int QUIET_ITEMS  = 150;
   localparam int DRAIN_CYCLES = 20;
   localparam kind_type KIND_UNUSED = 2'd3;

   // one predicted response
   typedef struct packed {
      logic [7:0] read_data;
      status_type status;
   } packet_status_type;

   logic clock;
   logic reset;

   dtpr_req_if req_ch ();
   dtpr_rsp_if rsp_ch ();

   delimited_text_packet_receiver #(
      .BUFFER_DEPTH (DEPTH)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // framer model state
   phase_code_type rx_phase;
   int             rx_wr_pos;
   logic           rx_ready;
   logic           rx_overflow;
   int             rx_length;
   logic [7:0]     rx_store [DEPTH];

   packet_status_type expected_status_q [$];
   int             error_count   = 0;
   int             items_sent    = 0;
   bit             quiet         = 0;
   bit             hold_request  = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // framer model: applies one item and returns the status after it
   function automatic packet_status_type predict_status(kind_type kind, logic [7:0] rx_byte,
                                                        logic [6:0] read_index);
      packet_status_type res;
      res = '0;
      case (kind)
         KIND_BYTE: begin
            case (rx_phase)
               PHASE_IDLE: begin
                  // start honored only with no packet pending
                  if (rx_byte == CH_START && !rx_ready) begin
                     rx_phase    = PHASE_PAYLOAD;
                     rx_wr_pos   = 0;
                     rx_overflow = 1'b0;
                  end
               end
               PHASE_PAYLOAD: begin
                  if (rx_byte == CH_CR) begin
                     rx_phase = PHASE_AFTER_CR;
                  end else if (rx_wr_pos < DEPTH - 1) begin
                     rx_store[rx_wr_pos] = rx_byte;
                     rx_wr_pos++;
                  end else begin
                     rx_overflow = 1'b1;
                  end
               end
               default: begin
                  // only LF finishes; anything else is dropped
                  if (rx_byte == CH_LF) begin
                     if (rx_wr_pos < DEPTH) rx_store[rx_wr_pos] = CH_TERM;
                     rx_length = rx_wr_pos;
                     rx_ready  = 1'b1;
                     rx_phase  = PHASE_IDLE;
                  end
               end
            endcase
         end
         KIND_CLEAR: rx_ready = 1'b0;
         KIND_READ: begin
            if (read_index < DEPTH) res.read_data = rx_store[read_index];
         end
         default: ;
      endcase
      res.status.packet_ready   = rx_ready;
      res.status.packet_length  = (rx_length > LEN_MAX) ? LEN_MAX : 7'(rx_length);
      res.status.overflow       = rx_overflow;
      res.status.receiver_phase = rx_phase;
      return res;
   endfunction

   // one request transfer, sometimes with a random gap in front of it
   task automatic send_item(kind_type kind, logic [7:0] rx_byte, logic [6:0] read_index);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.rx_byte    <= rx_byte;
      req_ch.read_index <= read_index;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_status_q.push_back(predict_status(kind, rx_byte, read_index));
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] rx_byte);
      send_item(KIND_BYTE, rx_byte, 7'($urandom_range(0, DEPTH - 1)));
   endtask

   // payload byte that never closes the payload
   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) b = CH_START;
      else if ($urandom_range(0, 31) == 0) b = CH_LF;
      if (b == CH_CR) b = CH_START;
      return b;
   endfunction

   // a well-formed packet, optionally with junk between CR and LF
   task automatic send_packet(int len, bit junk_after_cr);
      logic [7:0] b;
      send_byte(CH_START);
      repeat (len) send_byte(payload_byte());
      send_byte(CH_CR);
      if (junk_after_cr) begin
         repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF) b = CH_CR;
            send_byte(b);
         end
      end
      send_byte(CH_LF);
   endtask

   // field compare of one response
   task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      packet_status_type exp_s;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_status_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual data %0h", $time,
                     rsp_ch.read_data);
            error_count++;
         end else begin
            exp_s = expected_status_q.pop_front();
            check_field("read_data", exp_s.read_data, rsp_ch.read_data);
            check_field("packet_ready", exp_s.status.packet_ready, rsp_ch.packet_ready);
            check_field("packet_length", exp_s.status.packet_length, rsp_ch.packet_length);
            check_field("overflow", exp_s.status.overflow, rsp_ch.overflow);
            check_field("receiver_phase", exp_s.status.receiver_phase,
                        rsp_ch.receiver_phase);
         end
      end
   end

   // response ready: random stall bursts, plus one long hold on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
            rsp_ch.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // framing corner cases on short packets
   task automatic test_framing();
      send_item(KIND_BYTE, 8'h78, 7'd0);        // ignored while idle
      send_item(KIND_BYTE, CH_START, 7'd0);
      send_item(KIND_BYTE, CH_START, 7'd0);     // '@' kept as payload
      send_item(KIND_BYTE, 8'hFF, 7'd0);
      send_item(KIND_BYTE, 8'h00, 7'd0);
      send_item(KIND_BYTE, CH_CR, 7'd0);
      send_item(KIND_BYTE, 8'h5A, 7'd0);        // non-LF after CR dropped
      send_item(KIND_BYTE, CH_CR, 7'd0);
      send_item(KIND_BYTE, CH_LF, 7'd0);
      send_item(KIND_BYTE, CH_START, 7'd0);     // start while pending is ignored
      for (int i = 0; i < 4; i++) send_item(KIND_READ, 8'hFF, 7'(i));
      send_item(KIND_CLEAR, 8'h00, 7'd0);
      send_item(KIND_UNUSED, 8'hFF, 7'd1);
      // clear during payload leaves collection running
      send_item(KIND_BYTE, CH_START, 7'd0);
      send_item(KIND_BYTE, 8'h71, 7'd0);
      send_item(KIND_CLEAR, 8'h00, 7'd0);
      send_item(KIND_BYTE, CH_CR, 7'd0);
      send_item(KIND_BYTE, CH_LF, 7'd0);
      // empty packet
      send_item(KIND_CLEAR, 8'h00, 7'd0);
      send_item(KIND_BYTE, CH_START, 7'd0);
      send_item(KIND_BYTE, CH_CR, 7'd0);
      send_item(KIND_BYTE, CH_LF, 7'd0);
      send_item(KIND_READ, 8'h00, 7'd0);
   endtask

   // payload beyond capacity; afterwards every store entry has been written
   task automatic test_long_packet();
      send_item(KIND_CLEAR, 8'h00, 7'd0);
      send_packet(140, 1'b0);
      send_item(KIND_READ, 8'h00, 7'd126);
      send_item(KIND_READ, 8'h00, 7'd127);
      send_item(KIND_CLEAR, 8'h00, 7'd0);
      send_packet(3, 1'b1);
   endtask

   // long response stall while requests keep coming
   task automatic test_backpressure();
      hold_request = 1;
      repeat (40) begin
         send_item(kind_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, DEPTH - 1)));
      end
   endtask

   // random traffic, mostly well-formed packets
   task automatic test_random_traffic();
      int target;
      int choice;
      int len;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (items_sent >= target - QUIET_ITEMS) quiet = 1;
         choice = $urandom_range(0, 9);
         if (choice <= 5) begin
            if ($urandom_range(0, 3) != 0) send_item(KIND_CLEAR, 8'($urandom_range(0, 255)),
                                                     7'($urandom_range(0, DEPTH - 1)));
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 135)
                                              : $urandom_range(0, 12);
            send_packet(len, $urandom_range(0, 4) == 0);
            repeat ($urandom_range(0, 4)) begin
               send_item(KIND_READ, 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, DEPTH - 1)));
            end
         end else if (choice <= 7) begin
            // noise of every kind
            repeat ($urandom_range(1, 6)) begin
               send_item(kind_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, DEPTH - 1)));
            end
         end else if (choice == 8) begin
            // broken packet: start and payload, then stray bytes
            send_byte(CH_START);
            repeat ($urandom_range(0, 6)) send_byte(payload_byte());
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, DEPTH - 1)));
            repeat ($urandom_range(1, 3)) begin
               send_item(KIND_READ, 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, DEPTH - 1)));
            end
         end
      end
   endtask

   // main sequence
   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= KIND_BYTE;
      req_ch.rx_byte    <= 8'h00;
      req_ch.read_index <= 7'd0;
      rx_phase    = PHASE_IDLE;
      rx_wr_pos   = 0;
      rx_ready    = 1'b0;
      rx_overflow = 1'b0;
      rx_length   = 0;
      for (int i = 0; i < DEPTH; i++) rx_store[i] = 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_framing();
      test_long_packet();
      test_backpressure();
      test_random_traffic();
      req_ch.valid <= 1'b0;

      // drain outstanding responses, then allow for pipeline latency
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
